@@ hdl/slec_pkg.sv @@
package slec_pkg;

  // Wide enough for a ring length or a count up to the largest store (4096).
  localparam int LEN_W = 13;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_AMEND  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RESP
  } state_t;

  // HOLD: keep. SHIFT: pop head, push at tail. DROP: pop head, ring shrinks.
  // PUSH: push at tail without a pop, ring grows.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHIFT,
    CM_DROP,
    CM_PUSH
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [LEN_W-1:0] ring;
  } cell_ctl_t;

endpackage

@@ hdl/slec_if.sv @@
interface slec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] value;
  logic [6:0]  position;
  logic [31:0] new_value;
  modport source (output valid, opcode, value, position, new_value, input ready);
  modport sink   (input valid, opcode, value, position, new_value, output ready);
endinterface

interface slec_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [5:0] found_position;
  logic [6:0] removed_count;
  logic [6:0] list_length;
  modport source (output valid, status, found, found_position, removed_count, list_length,
                  input ready);
  modport sink   (input valid, status, found, found_position, removed_count, list_length,
                  output ready);
endinterface

@@ hdl/slec_cell.sv @@
module slec_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  slec_pkg::cell_ctl_t           ctl,
  input  logic [slec_pkg::DATA_W-1:0]   nbr_d,
  input  logic [slec_pkg::DATA_W-1:0]   push_d,
  output logic [slec_pkg::DATA_W-1:0]   data
);
  import slec_pkg::*;

  localparam logic [LEN_W-1:0] IDX_L  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] IDX1_L = LEN_W'(IDX + 1);

  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_SHIFT: begin
        if (IDX1_L < ctl.ring) begin
          data_r <= nbr_d;
        end else if (IDX1_L == ctl.ring) begin
          data_r <= push_d;
        end
      end
      CM_DROP: begin
        if (IDX1_L < ctl.ring) begin
          data_r <= nbr_d;
        end
      end
      CM_PUSH: begin
        if (IDX_L == ctl.ring) begin
          data_r <= push_d;
        end
      end
      default: ;
    endcase
  end

  assign data = data_r;

endmodule

@@ hdl/sequential_list_engine_unit.sv @@
// Sequential list engine: an ordered list of signed 32-bit values.
// Requests arrive on in_ch (opcode, value, position, new_value) and each
// gives exactly one transaction on out_ch (status, found, found_position,
// removed_count, list_length). Both channels use valid/ready; a transaction
// moves at a rising edge where both are high.
// cfg_we/cfg_wdata set capacity_in_use; write only while the block is idle.
// The entries live in a ring of DEPTH cells that, while a request is worked,
// rotates one place per cycle towards cell 0, save at the insert step; the
// controller inspects the head cell and pushes the same, a replaced or a new
// value in at the tail, or nothing to close a gap. A rejected insert (bad
// position or full) goes straight to its result; every other request is
// worked through one full rotation of the cell ring. One request is worked
// at a time: a new request is taken only once the last one has gone to the
// output register and the block is idle again.
// A finished result sits in the output register; a new request is accepted
// while it waits, but the next result holds until out_ch.ready takes the
// old one.
// Reset (rst_n low, synchronous) empties the list and sets the capacity to
// 64; cell contents are not cleared, entries past the length are never read.
module sequential_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  slec_in_if.sink     in_ch,
  slec_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import slec_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_M1 = LEN_W'(DEPTH - 1);

  state_t state_r, state_nxt;

  logic [6:0]        cap_r;
  logic [LEN_W-1:0]  count_r;
  logic [LEN_W-1:0]  k_r;
  logic [LEN_W-1:0]  ring_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W-1:0]  fpos_r;
  logic              found_r;
  logic              ins_done_r;
  status_t           stat_r;
  opcode_t           op_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] nv_r;
  logic [LEN_W-1:0]  pos_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_found_r;
  logic [5:0]        out_fpos_r;
  logic [6:0]        out_rem_r;
  logic [6:0]        out_len_r;

  logic [DATA_W-1:0] cell_d [DEPTH];
  logic [DATA_W-1:0] head, push_d;
  cell_ctl_t         ctl;

  logic              in_fire, slot_free;
  logic [LEN_W-1:0]  cap_ext, usable, in_pos;
  logic              ins_step, live, hit, finish, ins_nxt;
  logic [LEN_W-1:0]  k_nxt, pops;

  assign head    = cell_d[0];
  assign in_fire = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cap_ext = LEN_W'(cap_r);
  assign usable  = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
  assign in_pos  = LEN_W'(in_ch.position);

  // Step decode: the insert step pushes without a pop, all others pop one.
  assign ins_step = (op_r == OP_INSERT) && !ins_done_r && (k_r == pos_r);
  assign live     = k_r < count_r;
  assign hit      = live && (head == val_r);
  assign ins_nxt  = ins_done_r || ins_step;
  assign k_nxt    = ins_step ? k_r : k_r + 1'b1;
  assign pops     = (op_r == OP_INSERT) ? DEPTH_M1 : DEPTH_L;
  assign finish   = (state_r == S_RUN) && (k_nxt == pops) &&
                    ((op_r != OP_INSERT) || ins_nxt);

  // Cell ring: cell i takes from cell i+1, the tail cell from push_d.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (gi == DEPTH - 1) begin : g_tail
      assign nbr = push_d;
    end else begin : g_mid
      assign nbr = cell_d[gi+1];
    end
    slec_cell #(.IDX(gi)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .nbr_d  (nbr),
      .push_d (push_d),
      .data   (cell_d[gi])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_ch.opcode == OP_INSERT) &&
              ((in_pos > count_r) || (count_r >= usable))) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (finish) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and ring control.
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    ctl.ring    = ring_r;
    ctl.mode    = CM_HOLD;
    push_d      = head;
    if (state_r == S_RUN) begin
      if (ins_step) begin
        ctl.mode = CM_PUSH;
        push_d   = val_r;
      end else if ((op_r == OP_REMOVE) && hit) begin
        ctl.mode = CM_DROP;
      end else begin
        ctl.mode = CM_SHIFT;
        if ((op_r == OP_AMEND) && hit && !found_r) begin
          push_d = nv_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= 7'd64;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // Drop the taken result unless a new one replaces it this edge.
      if (out_valid_r && out_ch.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r       <= opcode_t'(in_ch.opcode);
            val_r      <= in_ch.value;
            nv_r       <= in_ch.new_value;
            pos_r      <= in_pos;
            k_r        <= '0;
            rem_r      <= '0;
            fpos_r     <= '0;
            found_r    <= 1'b0;
            ins_done_r <= 1'b0;
            ring_r     <= (in_ch.opcode == OP_INSERT) ? DEPTH_M1 : DEPTH_L;
            if ((in_ch.opcode == OP_INSERT) && (in_pos > count_r)) begin
              stat_r <= STAT_BADPOS;
            end else if ((in_ch.opcode == OP_INSERT) && (count_r >= usable)) begin
              stat_r <= STAT_FULL;
            end else begin
              stat_r <= STAT_OK;
            end
          end
        end
        S_RUN: begin
          k_r        <= k_nxt;
          ins_done_r <= ins_nxt;
          case (ctl.mode)
            CM_PUSH: ring_r <= ring_r + 1'b1;
            CM_DROP: begin
              ring_r <= ring_r - 1'b1;
              rem_r  <= rem_r + 1'b1;
            end
            default: ;
          endcase
          if (hit && !found_r && ((op_r == OP_FIND) || (op_r == OP_AMEND))) begin
            found_r <= 1'b1;
            fpos_r  <= k_r;
          end
          if (finish) begin
            case (op_r)
              OP_INSERT: count_r <= count_r + 1'b1;
              OP_REMOVE: begin
                // Count the drop of this last step too.
                count_r <= count_r - rem_r - LEN_W'(ctl.mode == CM_DROP);
                if ((rem_r == '0) && (ctl.mode != CM_DROP)) begin
                  stat_r <= STAT_NOTFOUND;
                end
              end
              default: begin
                if (!found_r && !hit) begin
                  stat_r <= STAT_NOTFOUND;
                end
              end
            endcase
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= stat_r;
            out_found_r  <= found_r;
            out_fpos_r   <= fpos_r[5:0];
            out_rem_r    <= rem_r[6:0];
            out_len_r    <= count_r[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.removed_count  = out_rem_r;
  assign out_ch.list_length    = out_len_r;

  // The ring never grows past the store, nor the scan past one rotation.
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_r <= DEPTH_L || state_r != S_RUN)
    else $error("ring length beyond store");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (k_r <= DEPTH_L))
    else $error("scan ran past one rotation");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_L)
    else $error("list length beyond store");

  a_nf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_NOTFOUND)) |-> !out_found_r)
    else $error("found flag set on a miss");

endmodule

@@ test/slec_list_checker.sv @@
module slec_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_new_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic        out_found,
  input  logic [5:0]  out_found_position,
  input  logic [6:0]  out_removed_count,
  input  logic [6:0]  out_list_length,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_results,
  output int          list_len
);
  import slec_pkg::*;

  typedef struct packed {
    status_t    status;
    logic       found;
    logic [5:0] fpos;
    logic [6:0] removed;
    logic [6:0] length;
  } list_result_t;

  localparam int DEPTH = 64;

  logic [31:0]  store [DEPTH];
  int           length_now;
  logic [6:0]   capacity;
  list_result_t expected_results [$];

  assign pending_results = expected_results.size();
  assign list_len = length_now;

  function automatic int usable_cap();
    return (capacity > DEPTH) ? DEPTH : int'(capacity);
  endfunction

  // Apply one request to the shadow list and return its result.
  function automatic list_result_t apply_request(opcode_t op, logic [31:0] v,
                                                 logic [6:0] pos, logic [31:0] nv);
    list_result_t r;
    int w;
    int hit;
    r = '0;
    r.status = STAT_OK;
    hit = -1;
    for (int i = 0; i < length_now; i++)
      if (hit < 0 && store[i] == v) hit = i;
    case (op)
      OP_FIND, OP_AMEND: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.fpos = hit[5:0];
          if (op == OP_AMEND) store[hit] = nv;
        end else r.status = STAT_NOTFOUND;
      end
      OP_INSERT: begin
        if (pos > length_now) r.status = STAT_BADPOS;
        else if (length_now >= usable_cap()) r.status = STAT_FULL;
        else begin
          for (int i = length_now; i > pos; i--) store[i] = store[i-1];
          store[pos] = v;
          length_now++;
        end
      end
      default: begin
        w = 0;
        for (int i = 0; i < length_now; i++)
          if (store[i] == v) r.removed++;
          else begin
            store[w] = store[i];
            w++;
          end
        length_now = w;
        if (r.removed == 0) r.status = STAT_NOTFOUND;
      end
    endcase
    r.length = length_now[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      length_now = 0;
      capacity <= 7'd64;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(opcode_t'(in_opcode), in_value,
                                                 in_position, in_new_value));
      if (out_valid && out_ready) begin
        got = {status_t'(out_status), out_found, out_found_position,
               out_removed_count, out_list_length};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d f=%0d p=%0d rm=%0d len=%0d",
                     $time, want.status, want.found, want.fpos, want.removed,
                     want.length);
            $display("%0t:          actual   st=%0d f=%0d p=%0d rm=%0d len=%0d",
                     $time, got.status, got.found, got.fpos, got.removed,
                     got.length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ test/sequential_list_engine_unit_tb.sv @@
module sequential_list_engine_unit_tb;
  import slec_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic       long_hold = 1'b0;
  int         fail_count;
  int         pending_results;
  int         list_len;
  int         quiet_cycles = 0;

  // Small pool of values so that find, remove and amend actually hit.
  logic [31:0] value_pool [8];

  slec_in_if  in_ch ();
  slec_out_if out_ch ();

  always #5 clk = ~clk;

  sequential_list_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  slec_list_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.opcode),
    .in_value(in_ch.value), .in_position(in_ch.position),
    .in_new_value(in_ch.new_value),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_found(out_ch.found), .out_found_position(out_ch.found_position),
    .out_removed_count(out_ch.removed_count), .out_list_length(out_ch.list_length),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_results(pending_results), .list_len(list_len)
  );

  // Offer one transaction after a random gap (none when no_gap is set), and hold it until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(opcode_t op, logic [31:0] v, logic [6:0] pos,
                              logic [31:0] nv, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value <= v;
    in_ch.position <= pos;
    in_ch.new_value <= nv;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    return ($urandom_range(0, 9) < 8) ? value_pool[$urandom_range(0, 7)] : $urandom();
  endfunction

  // Mostly legal positions, sometimes one past the end or anywhere.
  function automatic logic [6:0] pick_position();
    case ($urandom_range(0, 9))
      0: return 7'(list_len + 1);
      1: return 7'($urandom_range(0, 127));
      2: return 7'(list_len);
      default: return 7'($urandom_range(0, list_len));
    endcase
  endfunction

  // Receiver: random stalls per transaction, with a long hold-off on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_FIND;
    in_ch.value = '0;
    in_ch.position = '0;
    in_ch.new_value = '0;
    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0001, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h1234_5678};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: operations on the empty list, then extremes of every field.
    send_request(OP_FIND, 32'h8000_0000, 7'd0, 32'h0, 1'b0);
    send_request(OP_REMOVE, 32'h7FFF_FFFF, 7'd0, 32'h0, 1'b0);
    send_request(OP_AMEND, 32'h0, 7'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_INSERT, 32'h0, 7'd1, 32'h0, 1'b0);          // beyond length
    send_request(OP_INSERT, 32'h8000_0000, 7'd0, 32'h0, 1'b0);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 7'd1, 32'h0, 1'b0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 7'd0, 32'h0, 1'b0);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 7'd1, 32'h0, 1'b1);
    send_request(OP_INSERT, 32'h0, 7'd127, 32'h0, 1'b0);        // far beyond
    send_request(OP_FIND, 32'h7FFF_FFFF, 7'd127, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_AMEND, 32'h7FFF_FFFF, 7'd0, 32'h8000_0000, 1'b0);
    send_request(OP_REMOVE, 32'h8000_0000, 7'd0, 32'h0, 1'b0);   // two matches
    send_request(OP_FIND, 32'h1234_5678, 7'd64, 32'h0, 1'b0);
    send_request(OP_AMEND, 32'h1, 7'd0, 32'h2, 1'b0);

    // Capacity of one: existing entries stay, inserts are rejected as full.
    write_capacity(7'd1);
    send_request(OP_INSERT, 32'h5, 7'd0, 32'h0, 1'b0);
    send_request(OP_FIND, 32'h7FFF_FFFF, 7'd0, 32'h0, 1'b0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 7'd0, 32'h0, 1'b0);
    write_capacity(7'd0);
    send_request(OP_INSERT, 32'h5, 7'd0, 32'h0, 1'b0);
    write_capacity(7'd127);                                       // clipped to DEPTH

    // Fill to the brim with the input side hammering while the receiver holds off.
    long_hold = 1'b1;
    repeat (70) send_request(OP_INSERT, value_pool[$urandom_range(0, 7)],
                             7'($urandom_range(0, list_len)), 32'h0, 1'b1);
    send_request(OP_FIND, $urandom(), 7'd64, 32'h0, 1'b0);
    wait_drained();

    // Random phases across several capacities.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_capacity(7'd64);
        1: write_capacity(7'd3);
        2: write_capacity(7'($urandom_range(1, 63)));
        3: write_capacity(7'd65);
        4: write_capacity(7'd1);
        default: write_capacity(7'd64);
      endcase
      for (int n = 0; n < 230; n++) begin
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
          send_request(OP_INSERT, pick_value(), pick_position(), $urandom(), 1'b0);
        else if (sel < 6)
          send_request(OP_FIND, pick_value(), 7'($urandom()), $urandom(), 1'b0);
        else if (sel < 7)
          send_request(OP_REMOVE, pick_value(), 7'($urandom()), $urandom(), 1'b0);
        else
          send_request(OP_AMEND, pick_value(), 7'($urandom()), pick_value(), 1'b0);
        // occasionally stop and let everything drain
        if (n % 97 == 50) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ files.f @@
hdl/slec_pkg.sv
hdl/slec_if.sv
hdl/slec_cell.sv
hdl/sequential_list_engine_unit.sv
test/slec_list_checker.sv
test/sequential_list_engine_unit_tb.sv
